// ===== sv/lcr_pkg.sv =====
`timescale 1ns / 1ps

package lcr_pkg;

  // Converter word and averaging depth
  localparam int SAMPLE_BITS = 24;
  localparam int MAX_AVERAGE = 16;

  // Register and field widths
  localparam int GAIN_W     = 2;
  localparam int AVGC_W     = 5;
  localparam int OFFSET_W   = 24;
  localparam int SCALE_W    = 32;
  localparam int SCALE_FRAC = 16;
  localparam int TIMEOUT_W  = 20;
  localparam int RAW_W      = 24;
  localparam int WEIGHT_W   = 32;

  // Derived datapath widths
  localparam int PULSE_W   = $clog2(SAMPLE_BITS + (1 << GAIN_W));
  localparam int N_W       = $clog2(MAX_AVERAGE + 1);
  localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_AVERAGE);
  localparam int DIV_CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
  localparam int DIFF_W    = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 1;
  localparam int PROD_W    = DIFF_W + SCALE_W;
  localparam int QUOT_W    = PROD_W - SCALE_FRAC;

  // Port widths and bit positions
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int IN_DATA_W    = 8;
  localparam int IN_START_BIT = 0;
  localparam int IN_DATA_BIT  = 1;
  localparam int OUT_DATA_W   = 64;
  localparam int OUT_PAD_W    = OUT_DATA_W - (4 + RAW_W + WEIGHT_W);

  // Saturation limits
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  // Register reset values
  localparam logic [GAIN_W-1:0]    GAIN_RST    = GAIN_W'(1);
  localparam logic [AVGC_W-1:0]    AVGC_RST    = AVGC_W'(3);
  localparam logic [OFFSET_W-1:0]  OFFSET_RST  = '0;
  localparam logic [SCALE_W-1:0]   SCALE_RST   = SCALE_W'(65536);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(1001000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PULSES   = 3'd0,
    REG_AVERAGE_COUNT = 3'd1,
    REG_ZERO_OFFSET   = 3'd2,
    REG_SCALE_FACTOR  = 3'd3,
    REG_READY_TIMEOUT = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WAIT,
    ST_CLK_LO,
    ST_CLK_HI,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_SAT
  } state_t;

  typedef struct packed {
    logic run_clear;
    logic wait_inc;
    logic wait_clear;
    logic shift_init;
    logic pulse_step;
    logic sample_add;
    logic div_load;
    logic div_step;
    logic diff_calc;
    logic mul_calc;
    logic result_write;
    logic out_load;
    logic clock_line;
    logic busy;
    logic done;
    logic timed_out;
  } cmd_t;

  typedef struct packed {
    logic wait_hit;
    logic pulse_last;
    logic sample_last;
    logic div_last;
  } status_t;

endpackage

// ===== sv/load_cell_adc_serial_reader.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+---------------------------------------------
// in_      | in  | in_tvalid/in_tready   | one half-bit tick: start_req, data_line
// out_     | out | out_tvalid/out_tready | one result per tick: pin, flags, mean, weight
// cfg_     | in  | cfg_valid/cfg_ready   | register index and write data
//
// The tick that completes the last reading of a measurement has its beat loaded only after
// the arithmetic tail (load, 28 divider steps by the reading count, offset subtract,
// multiply, saturate), and no tick is taken meanwhile.
// Reset (rst_n low, synchronous) restores the register defaults and idles the readout
// with the held mean and weight at zero.
// A waiting result blocks the next tick only while out_tready is low.
module load_cell_adc_serial_reader (
  input  logic                               clk,
  input  logic                               rst_n,
  // [0] start_req, [1] data_line, [7:2] zero
  input  logic [lcr_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] clock_line, [1] busy_res, [2] done_res, [3] timed_out,
  // [27:4] raw_average, [59:28] weight, [63:60] zero
  output logic [lcr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lcr_pkg::cmd_t    cmd;
  lcr_pkg::status_t status;

  // Register writes are always accepted, never stalled
  assign cfg_ready = 1'b1;

  // Sequence the readout and the final arithmetic
  lcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .start_req  (in_tdata[lcr_pkg::IN_START_BIT]),
    .data_line  (in_tdata[lcr_pkg::IN_DATA_BIT]),
    .out_tready (out_tready),
    .status     (status),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // Shift in the reading, accumulate, divide, scale and hold the beat payload
  lcr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_line (in_tdata[lcr_pkg::IN_DATA_BIT]),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

// ===== sv/lcr_ctrl.sv =====
`timescale 1ns / 1ps

module lcr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            start_req,
  input  logic            data_line,
  input  logic            out_tready,
  input  lcr_pkg::status_t status,
  output logic            in_tready,
  output logic            out_tvalid,
  output lcr_pkg::cmd_t   cmd
);

  lcr_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            tick_state;
  logic            acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign tick_state = (state_r == lcr_pkg::ST_IDLE)   || (state_r == lcr_pkg::ST_WAIT) ||
                      (state_r == lcr_pkg::ST_CLK_LO) || (state_r == lcr_pkg::ST_CLK_HI);
  assign in_tready  = tick_state && (!out_valid_r || out_tready);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      lcr_pkg::ST_IDLE: begin
        if (acc) begin
          cmd.out_load = 1'b1;
          if (start_req) begin
            cmd.run_clear = 1'b1;
            cmd.busy      = 1'b1;
            state_nxt     = lcr_pkg::ST_WAIT;
          end
        end
      end
      lcr_pkg::ST_WAIT: begin
        if (acc) begin
          cmd.out_load = 1'b1;
          cmd.busy     = 1'b1;
          if (!data_line) begin
            cmd.shift_init = 1'b1;
            state_nxt      = lcr_pkg::ST_CLK_LO;
          end else begin
            cmd.wait_inc = 1'b1;
            if (status.wait_hit) begin
              cmd.busy      = 1'b0;
              cmd.done      = 1'b1;
              cmd.timed_out = 1'b1;
              state_nxt     = lcr_pkg::ST_IDLE;
            end
          end
        end
      end
      lcr_pkg::ST_CLK_LO: begin
        if (acc) begin
          cmd.out_load   = 1'b1;
          cmd.busy       = 1'b1;
          cmd.clock_line = 1'b1;
          state_nxt      = lcr_pkg::ST_CLK_HI;
        end
      end
      lcr_pkg::ST_CLK_HI: begin
        if (acc) begin
          cmd.pulse_step = 1'b1;
          cmd.busy       = 1'b1;
          if (status.pulse_last) begin
            cmd.sample_add = 1'b1;
            if (status.sample_last) begin
              // Result goes out once the mean and weight are ready
              state_nxt = lcr_pkg::ST_DIV_LOAD;
            end else begin
              cmd.out_load   = 1'b1;
              cmd.wait_clear = 1'b1;
              state_nxt      = lcr_pkg::ST_WAIT;
            end
          end else begin
            cmd.out_load = 1'b1;
            state_nxt    = lcr_pkg::ST_CLK_LO;
          end
        end
      end
      lcr_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = lcr_pkg::ST_DIV;
      end
      lcr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = lcr_pkg::ST_DIFF;
        end
      end
      lcr_pkg::ST_DIFF: begin
        cmd.diff_calc = 1'b1;
        state_nxt     = lcr_pkg::ST_MUL;
      end
      lcr_pkg::ST_MUL: begin
        cmd.mul_calc = 1'b1;
        state_nxt    = lcr_pkg::ST_SAT;
      end
      lcr_pkg::ST_SAT: begin
        cmd.result_write = 1'b1;
        cmd.out_load     = 1'b1;
        cmd.done         = 1'b1;
        state_nxt        = lcr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

endmodule

// ===== sv/lcr_datapath.sv =====
`timescale 1ns / 1ps

module lcr_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                data_line,
  input  lcr_pkg::cmd_t                       cmd,
  output lcr_pkg::status_t                    status,
  output logic [lcr_pkg::OUT_DATA_W-1:0]      out_tdata
);

  // Configuration registers
  logic [lcr_pkg::GAIN_W-1:0]    gain_pulses_r;
  logic [lcr_pkg::AVGC_W-1:0]    average_count_r;
  logic [lcr_pkg::OFFSET_W-1:0]  zero_offset_r;
  logic [lcr_pkg::SCALE_W-1:0]   scale_factor_r;
  logic [lcr_pkg::TIMEOUT_W-1:0] ready_timeout_r;

  // Readout state
  logic [lcr_pkg::TIMEOUT_W-1:0]   wait_count_r;
  logic [lcr_pkg::PULSE_W-1:0]     pulse_r;
  logic [lcr_pkg::SAMPLE_BITS-1:0] shift_r;
  logic signed [lcr_pkg::SUM_W-1:0] sum_r;
  logic [lcr_pkg::N_W-1:0]         taken_r;

  // Divider, difference and product
  logic [lcr_pkg::N_W-1:0]       rem_r;
  logic [lcr_pkg::SUM_W-1:0]     quo_r;
  logic                          sum_neg_r;
  logic [lcr_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [lcr_pkg::RAW_W-1:0]     mean_r;
  logic [lcr_pkg::DIFF_W-1:0]    dmag_r;
  logic                          dneg_r;
  logic [lcr_pkg::PROD_W-1:0]    prod_r;
  logic                          pneg_r;

  // Held results and output register
  logic [lcr_pkg::RAW_W-1:0]      last_average_r;
  logic [lcr_pkg::WEIGHT_W-1:0]   last_weight_r;
  logic [lcr_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [lcr_pkg::TIMEOUT_W-1:0]   wait_inc;
  logic [lcr_pkg::PULSE_W:0]       pulse_inc, pulse_end;
  logic [lcr_pkg::N_W:0]           taken_inc;
  logic [lcr_pkg::N_W-1:0]         n_avg;
  logic [lcr_pkg::SAMPLE_BITS-1:0] shift_nxt;
  logic signed [lcr_pkg::SUM_W-1:0] sample_ext;
  logic [lcr_pkg::N_W:0]           rem_sh, rem_sub;
  logic                            q_bit;
  logic [lcr_pkg::SUM_W-1:0]       mean_full;
  logic signed [lcr_pkg::DIFF_W-1:0] mean_ext, off_ext, diff;
  logic [lcr_pkg::QUOT_W-1:0]      scaled;
  logic                            over;
  logic [lcr_pkg::WEIGHT_W-1:0]    weight_new;
  logic [lcr_pkg::RAW_W-1:0]       avg_sel;
  logic [lcr_pkg::WEIGHT_W-1:0]    weight_sel;

  // Count of readings per measurement, zero taken as one, above MAX_AVERAGE clamped to it
  always_comb begin
    if (average_count_r == '0) begin
      n_avg = lcr_pkg::N_W'(1);
    end else if (32'(average_count_r) > lcr_pkg::MAX_AVERAGE) begin
      n_avg = lcr_pkg::N_W'(lcr_pkg::MAX_AVERAGE);
    end else begin
      n_avg = lcr_pkg::N_W'(average_count_r);
    end
  end

  assign wait_inc  = wait_count_r + lcr_pkg::TIMEOUT_W'(1);
  assign pulse_inc = {1'b0, pulse_r} + (lcr_pkg::PULSE_W+1)'(1);
  assign pulse_end = (lcr_pkg::PULSE_W+1)'(lcr_pkg::SAMPLE_BITS) +
                     (lcr_pkg::PULSE_W+1)'(gain_pulses_r);
  assign taken_inc = {1'b0, taken_r} + (lcr_pkg::N_W+1)'(1);
  assign shift_nxt = (32'(pulse_r) < lcr_pkg::SAMPLE_BITS) ?
                     {shift_r[lcr_pkg::SAMPLE_BITS-2:0], data_line} : shift_r;
  assign sample_ext = lcr_pkg::SUM_W'($signed(shift_nxt));

  assign status.wait_hit    = (wait_inc >= ready_timeout_r);
  assign status.pulse_last  = (pulse_inc >= pulse_end);
  assign status.sample_last = (taken_inc >= {1'b0, n_avg});
  assign status.div_last    = (div_cnt_r == lcr_pkg::DIV_CNT_W'(lcr_pkg::SUM_W - 1));

  // One quotient bit per step, restoring
  assign rem_sh  = {rem_r, quo_r[lcr_pkg::SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, n_avg};
  assign q_bit   = (rem_sh >= {1'b0, n_avg});

  assign mean_full = sum_neg_r ? (lcr_pkg::SUM_W'(0) - quo_r) : quo_r;
  assign mean_ext  = lcr_pkg::DIFF_W'($signed(mean_full[lcr_pkg::SAMPLE_BITS-1:0]));
  assign off_ext   = lcr_pkg::DIFF_W'($signed(zero_offset_r));
  assign diff      = mean_ext - off_ext;

  assign scaled = prod_r[lcr_pkg::PROD_W-1:lcr_pkg::SCALE_FRAC];
  assign over   = |scaled[lcr_pkg::QUOT_W-1:lcr_pkg::WEIGHT_W-1];

  always_comb begin
    if (pneg_r) begin
      weight_new = over ? lcr_pkg::WEIGHT_MIN :
                   (lcr_pkg::WEIGHT_W'(0) - scaled[lcr_pkg::WEIGHT_W-1:0]);
    end else begin
      weight_new = over ? lcr_pkg::WEIGHT_MAX : scaled[lcr_pkg::WEIGHT_W-1:0];
    end
  end

  assign avg_sel    = cmd.result_write ? mean_r     : last_average_r;
  assign weight_sel = cmd.result_write ? weight_new : last_weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_pulses_r   <= lcr_pkg::GAIN_RST;
      average_count_r <= lcr_pkg::AVGC_RST;
      zero_offset_r   <= lcr_pkg::OFFSET_RST;
      scale_factor_r  <= lcr_pkg::SCALE_RST;
      ready_timeout_r <= lcr_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (lcr_pkg::cfg_reg_t'(cfg_index))
        lcr_pkg::REG_GAIN_PULSES:   gain_pulses_r   <= cfg_data[lcr_pkg::GAIN_W-1:0];
        lcr_pkg::REG_AVERAGE_COUNT: average_count_r <= cfg_data[lcr_pkg::AVGC_W-1:0];
        lcr_pkg::REG_ZERO_OFFSET:   zero_offset_r   <= cfg_data[lcr_pkg::OFFSET_W-1:0];
        lcr_pkg::REG_SCALE_FACTOR:  scale_factor_r  <= cfg_data[lcr_pkg::SCALE_W-1:0];
        lcr_pkg::REG_READY_TIMEOUT: ready_timeout_r <= cfg_data[lcr_pkg::TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_count_r   <= '0;
      pulse_r        <= '0;
      shift_r        <= '0;
      sum_r          <= '0;
      taken_r        <= '0;
      last_average_r <= '0;
      last_weight_r  <= '0;
    end else begin
      if (cmd.run_clear) begin
        sum_r        <= '0;
        taken_r      <= '0;
        wait_count_r <= '0;
      end
      if (cmd.wait_inc) begin
        wait_count_r <= wait_inc;
      end
      if (cmd.wait_clear) begin
        wait_count_r <= '0;
      end
      if (cmd.shift_init) begin
        pulse_r <= '0;
        shift_r <= '0;
      end
      if (cmd.pulse_step) begin
        pulse_r <= pulse_inc[lcr_pkg::PULSE_W-1:0];
        shift_r <= shift_nxt;
      end
      if (cmd.sample_add) begin
        sum_r   <= sum_r + sample_ext;
        taken_r <= taken_inc[lcr_pkg::N_W-1:0];
      end
      if (cmd.result_write) begin
        last_average_r <= mean_r;
        last_weight_r  <= weight_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      sum_neg_r <= sum_r[lcr_pkg::SUM_W-1];
      quo_r     <= sum_r[lcr_pkg::SUM_W-1] ? (lcr_pkg::SUM_W'(0) - sum_r) : sum_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= q_bit ? rem_sub[lcr_pkg::N_W-1:0] : rem_sh[lcr_pkg::N_W-1:0];
      quo_r     <= {quo_r[lcr_pkg::SUM_W-2:0], q_bit};
      div_cnt_r <= div_cnt_r + lcr_pkg::DIV_CNT_W'(1);
    end
    if (cmd.diff_calc) begin
      mean_r <= mean_ext[lcr_pkg::RAW_W-1:0];
      dneg_r <= diff[lcr_pkg::DIFF_W-1];
      dmag_r <= diff[lcr_pkg::DIFF_W-1] ? (lcr_pkg::DIFF_W'(0) - diff) : diff;
    end
    if (cmd.mul_calc) begin
      prod_r <= lcr_pkg::PROD_W'(dmag_r) * lcr_pkg::PROD_W'(scale_factor_r);
      pneg_r <= dneg_r;
    end
    if (cmd.out_load) begin
      out_data_r <= {{lcr_pkg::OUT_PAD_W{1'b0}}, weight_sel, avg_sel,
                     cmd.timed_out, cmd.done, cmd.busy, cmd.clock_line};
    end
  end

  assign out_tdata = out_data_r;

endmodule

// ===== sv/lcr_checker.sv =====
`timescale 1ns / 1ps

module lcr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [lcr_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A timeout always ends the measurement
  a_tmo_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[2])
    else $error("timed_out without done_res");

  // A finished measurement is no longer busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1])
    else $error("done_res while busy_res");

  // The converter clock is only driven during a measurement
  a_clock_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("clock_line high while idle");

  // A stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed under stall");

endmodule

bind load_cell_adc_serial_reader lcr_checker u_lcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/load_cell_adc_serial_reader_tb.sv =====
`timescale 1ns / 1ps

// Load-cell readout testbench: every input beat is one half-bit tick, and every
// tick yields one result beat. A tick-level predictor of the readout runs beside the
// block. It is advanced once per accepted tick, and each result beat is checked
// field by field against the oldest prediction.
module load_cell_adc_serial_reader_tb;

  localparam int CYCLE_LIMIT   = 1_000_000;
  // Covers the divide/multiply tail of a measurement with margin
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 60;
  // Pass as tmo_after when the data line must never be held high into a timeout
  localparam int NEVER         = 99;

  typedef enum logic [1:0] {RD_IDLE, RD_WAIT, RD_SHIFT} rd_phase_t;

  typedef struct packed {
    logic                         clk_line;
    logic                         busy;
    logic                         done;
    logic                         timed_out;
    logic [lcr_pkg::RAW_W-1:0]    mean;
    logic [lcr_pkg::WEIGHT_W-1:0] weight;
  } tick_result_t;

  logic                           clk;
  logic                           rst_n;
  logic [lcr_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [lcr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [lcr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lcr_pkg::CFG_DATA_W-1:0] cfg_data;

  load_cell_adc_serial_reader uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers
  logic [lcr_pkg::GAIN_W-1:0]    reg_gain;
  logic [lcr_pkg::AVGC_W-1:0]    reg_avg;
  logic [lcr_pkg::OFFSET_W-1:0]  reg_offset;
  logic [lcr_pkg::SCALE_W-1:0]   reg_scale;
  logic [lcr_pkg::TIMEOUT_W-1:0] reg_timeout;

  // Predictor copy of the readout state
  rd_phase_t                        rd_phase;
  int                               rd_pulses;
  logic                             rd_clk_hi;
  logic [lcr_pkg::SAMPLE_BITS-1:0]  rd_word;
  longint                           rd_sum;
  int                               rd_taken;
  logic [lcr_pkg::TIMEOUT_W-1:0]    rd_wait;
  logic [lcr_pkg::RAW_W-1:0]        held_mean;
  logic [lcr_pkg::WEIGHT_W-1:0]     held_weight;

  tick_result_t                    expected_ticks[$];
  // Converter words to present on the data line, oldest first; random bits when empty
  logic [lcr_pkg::SAMPLE_BITS-1:0] reading_words[$];

  int errors       = 0;
  int ticks_sent   = 0;
  int cycle_count  = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic reset_predictor();
    reg_gain    = lcr_pkg::GAIN_RST;
    reg_avg     = lcr_pkg::AVGC_RST;
    reg_offset  = lcr_pkg::OFFSET_RST;
    reg_scale   = lcr_pkg::SCALE_RST;
    reg_timeout = lcr_pkg::TIMEOUT_RST;
    rd_phase    = RD_IDLE;
    rd_pulses   = 0;
    rd_clk_hi   = 1'b0;
    rd_word     = '0;
    rd_sum      = 0;
    rd_taken    = 0;
    rd_wait     = '0;
    held_mean   = '0;
    held_weight = '0;
  endtask

  // Q16.16 scaling of the offset-corrected mean: truncate the magnitude,
  // restore the sign, then clamp to the signed 32-bit range.
  function automatic logic [lcr_pkg::WEIGHT_W-1:0] scaled_weight(input longint diff);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = (mag * 64'(reg_scale)) >> lcr_pkg::SCALE_FRAC;
    if (diff < 0)
      return (prod >= 64'h8000_0000) ? lcr_pkg::WEIGHT_MIN : (~prod[31:0] + 32'd1);
    return (prod > 64'h7FFF_FFFF) ? lcr_pkg::WEIGHT_MAX : prod[31:0];
  endfunction

  // Advance the readout by one tick and return the levels it shows afterwards
  function automatic tick_result_t predict_tick(input bit start, input bit dat);
    tick_result_t r;
    int           n;
    longint       mean;
    r = '0;
    case (rd_phase)
      RD_IDLE: begin
        if (start) begin
          rd_phase  = RD_WAIT;
          rd_sum    = 0;
          rd_taken  = 0;
          rd_wait   = '0;
          rd_clk_hi = 1'b0;
        end
      end
      RD_WAIT: begin
        if (!dat) begin
          rd_phase  = RD_SHIFT;
          rd_pulses = 0;
          rd_clk_hi = 1'b0;
          rd_word   = '0;
        end else begin
          rd_wait = rd_wait + 1'b1;
          if (rd_wait >= reg_timeout) begin
            rd_phase    = RD_IDLE;
            r.done      = 1'b1;
            r.timed_out = 1'b1;
            rd_sum      = 0;
          end
        end
      end
      default: begin
        if (!rd_clk_hi) begin
          rd_clk_hi = 1'b1;
        end else begin
          // falling half of the pulse: sample, then count the pulse
          rd_clk_hi = 1'b0;
          if (rd_pulses < lcr_pkg::SAMPLE_BITS)
            rd_word = {rd_word[lcr_pkg::SAMPLE_BITS-2:0], dat};
          rd_pulses++;
          if (rd_pulses >= lcr_pkg::SAMPLE_BITS + int'(reg_gain)) begin
            n = int'(reg_avg);
            if (n == 0) n = 1;
            if (n > lcr_pkg::MAX_AVERAGE) n = lcr_pkg::MAX_AVERAGE;
            rd_sum += longint'($signed(rd_word));
            rd_taken++;
            if (rd_taken >= n) begin
              mean        = rd_sum / longint'(n);
              held_mean   = mean[lcr_pkg::RAW_W-1:0];
              held_weight = scaled_weight(mean - longint'($signed(reg_offset)));
              rd_phase    = RD_IDLE;
              r.done      = 1'b1;
            end else begin
              rd_phase = RD_WAIT;
              rd_wait  = '0;
            end
          end
        end
      end
    endcase
    r.clk_line = rd_clk_hi;
    r.busy     = (rd_phase != RD_IDLE);
    r.mean     = held_mean;
    r.weight   = held_weight;
    return r;
  endfunction

  // Offer one tick, hold it until accepted, then record what it must produce
  task automatic send_tick(input bit start, input bit dat);
    logic [lcr_pkg::IN_DATA_W-1:0] beat;
    beat = '0;
    beat[lcr_pkg::IN_START_BIT] = start;
    beat[lcr_pkg::IN_DATA_BIT]  = dat;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_ticks.push_back(predict_tick(start, dat));
    ticks_sent++;
  endtask

  // Run one measurement to its end (or finish the one under way). The converter
  // answers after short random delays; from reading tmo_after on it never answers.
  task automatic run_measurement(input int tmo_after);
    bit st;
    bit dat;
    if (rd_phase == RD_IDLE)
      send_tick(1'b1, 1'($urandom_range(1)));
    while (rd_phase != RD_IDLE) begin
      st = 1'($urandom_range(1));
      if (rd_phase == RD_WAIT) begin
        if (rd_taken >= tmo_after)
          dat = 1'b1;
        else
          // stay high only while the next high tick cannot trip the timeout
          dat = (32'(rd_wait) + 1 < 32'(reg_timeout)) && ($urandom_range(2) == 0);
      end else if (rd_clk_hi && rd_pulses < lcr_pkg::SAMPLE_BITS &&
                   reading_words.size() > 0) begin
        dat = reading_words[0][lcr_pkg::SAMPLE_BITS-1-rd_pulses];
        if (rd_pulses == lcr_pkg::SAMPLE_BITS - 1)
          void'(reading_words.pop_front());
      end else begin
        dat = 1'($urandom_range(1));
      end
      send_tick(st, dat);
    end
  endtask

  task automatic noise_ticks(input int count);
    repeat (count) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Bring the block to rest: finish any measurement, drop valid, drain results,
  // then let the arithmetic tail run out.
  task automatic settle();
    if (rd_phase != RD_IDLE)
      run_measurement(NEVER);
    in_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes keep it asserted
  task automatic write_reg(input lcr_pkg::cfg_reg_t idx,
                           input logic [lcr_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lcr_pkg::REG_GAIN_PULSES:   reg_gain    = val[lcr_pkg::GAIN_W-1:0];
      lcr_pkg::REG_AVERAGE_COUNT: reg_avg     = val[lcr_pkg::AVGC_W-1:0];
      lcr_pkg::REG_ZERO_OFFSET:   reg_offset  = val[lcr_pkg::OFFSET_W-1:0];
      lcr_pkg::REG_SCALE_FACTOR:  reg_scale   = val[lcr_pkg::SCALE_W-1:0];
      lcr_pkg::REG_READY_TIMEOUT: reg_timeout = val[lcr_pkg::TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [31:0] gain, input logic [31:0] avg,
                               input logic [31:0] offset, input logic [31:0] scale,
                               input logic [31:0] timeout);
    settle();
    write_reg(lcr_pkg::REG_GAIN_PULSES, gain);
    write_reg(lcr_pkg::REG_AVERAGE_COUNT, avg);
    write_reg(lcr_pkg::REG_ZERO_OFFSET, offset);
    write_reg(lcr_pkg::REG_SCALE_FACTOR, scale);
    write_reg(lcr_pkg::REG_READY_TIMEOUT, timeout);
    cfg_valid <= 1'b0;
  endtask

  // Random setting; junk above each field is sometimes written too
  task automatic apply_random_setting();
    logic [31:0] junk;
    logic [31:0] avg;
    logic [31:0] scale;
    logic [31:0] timeout;
    junk  = $urandom_range(1) ? $urandom : 32'd0;
    avg   = ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(0, 5);
    scale = $urandom_range(1) ? $urandom : $urandom_range(0, 32'h0004_0000);
    case ($urandom_range(9))
      0:       timeout = 0;
      1:       timeout = $urandom_range(0, 20'hFFFFF);
      default: timeout = $urandom_range(1, 40);
    endcase
    apply_setting((junk & ~32'h3) | $urandom_range(3), (junk & ~32'h1F) | avg, $urandom,
                  scale, (junk & ~32'hFFFFF) | timeout);
  endtask

  // Reset values: averaging of three readings at both ends of the code range
  task automatic test_reset_setting();
    reading_words = '{24'h7FFFFF, 24'h800000, 24'h000001};
    run_measurement(NEVER);
    noise_ticks(6);
  endtask

  // Weight clamps at both ends, zero scale, mean truncated toward zero
  task automatic test_weight_extremes();
    apply_setting(3, 1, 32'h0080_0000, 32'hFFFF_FFFF, 20);
    reading_words = '{24'h7FFFFF};
    run_measurement(NEVER);
    apply_setting(2, 1, 32'h007F_FFFF, 32'hFFFF_FFFF, 20);
    reading_words = '{24'h800000};
    run_measurement(NEVER);
    apply_setting(1, 2, 0, 0, 20);
    reading_words = '{24'h123456, 24'hFEDCBA};
    run_measurement(NEVER);
    // -1 and -2 average to -1, not -2
    apply_setting(1, 2, 32'h0000_0010, 32'h0001_8000, 20);
    reading_words = '{24'hFFFFFF, 24'hFFFFFE};
    run_measurement(NEVER);
  endtask

  // No gain pulses, zero count taken as one, a count past the maximum
  task automatic test_count_limits();
    apply_setting(0, 0, $urandom, 32'h0001_0000, 20);
    run_measurement(NEVER);
    apply_setting(0, 31, 0, 32'h0000_4000, 20);
    run_measurement(NEVER);
  endtask

  // Zero timeout trips on the first high tick; a late timeout keeps the held mean
  task automatic test_timeouts();
    apply_setting(1, 1, 0, 32'h0001_0000, 0);
    run_measurement(0);
    apply_setting(2, 2, $urandom, $urandom, 7);
    run_measurement(1);
    apply_setting(1, 1, $urandom, $urandom, 32'h000F_FFFF);
    run_measurement(NEVER);
  endtask

  // Hold the receiver off for a long stretch while ticks keep coming, so that
  // the block fills and stalls its input
  task automatic test_backpressure();
    apply_setting(1, 1, $urandom, $urandom, 50);
    hold_request = 400;
    run_measurement(NEVER);
  endtask

  // Mostly complete measurements with random data, some timeouts, some noise,
  // across the idling mixes
  task automatic test_random_traffic();
    int first;
    int pick;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 72; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      apply_random_setting();
      first = ticks_sent;
      while (ticks_sent - first < 40) begin
        pick = $urandom_range(99);
        if (pick < 75)
          run_measurement(NEVER);
        else if (pick < 87 && reg_timeout <= 64)
          run_measurement($urandom_range(0, 3));
        else
          noise_ticks($urandom_range(1, 20));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want_v, got_v);
    end
  endtask

  // Compare every result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_ticks.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected, expected none got %h",
                   $time, out_tdata);
      end else begin
        want = expected_ticks.pop_front();
        check_field("clock_line", 32'(want.clk_line), 32'(out_tdata[0]));
        check_field("busy_res", 32'(want.busy), 32'(out_tdata[1]));
        check_field("done_res", 32'(want.done), 32'(out_tdata[2]));
        check_field("timed_out", 32'(want.timed_out), 32'(out_tdata[3]));
        check_field("raw_average", 32'(want.mean), 32'(out_tdata[4 +: lcr_pkg::RAW_W]));
        check_field("weight", want.weight,
                    out_tdata[4 + lcr_pkg::RAW_W +: lcr_pkg::WEIGHT_W]);
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin : receiver
    int held;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        held         = hold_request;
        hold_request = 0;
        out_tready <= 1'b0;
        repeat (held) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL load_cell_adc_serial_reader");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = lcr_pkg::REG_GAIN_PULSES;
    cfg_data  = '0;
    reset_predictor();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_setting();
    test_weight_extremes();
    test_count_limits();
    test_timeouts();
    test_backpressure();
    test_random_traffic();

    settle();
    if (errors == 0)
      $display("PASS load_cell_adc_serial_reader");
    else
      $display("FAIL load_cell_adc_serial_reader");
    $finish;
  end

endmodule
